// ===== src/mono_framebuffer_draw_engine_top_macros.svh =====
// assertion macros for the frame buffer draw engine top level
// expects clk and arst_n in the scope of the module that uses them
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define FBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fbd_pkg.sv =====
// shared types, constants and helper functions for the frame buffer draw engine
// no dependencies
package fbd_pkg;

	localparam int BUFFER_BYTES = 1024;
	localparam int ROW_BYTES    = 32;
	localparam int BUF_AW       = $clog2(BUFFER_BYTES);
	localparam int COL_W        = $clog2(ROW_BYTES);

	localparam logic [7:0] SYNC_CMD  = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam logic [7:0] ROW_CMD   = 8'h80;
	localparam logic [6:0] MAX_X     = 7'd127;
	localparam logic [5:0] MAX_Y     = 6'd63;
	localparam logic [BUF_AW-1:0] LAST_ADDR = BUF_AW'(BUFFER_BYTES - 1);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(ROW_BYTES - 1);

	typedef enum logic [2:0] {
		CMD_PIXEL = 3'd0,
		CMD_FILL  = 3'd1,
		CMD_INV   = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_ROW   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK = 3'd0,
		STS_XA = 3'd1,
		STS_YA = 3'd2,
		STS_XB = 3'd3,
		STS_YB = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_CLR,
		OP_SET,
		OP_INV
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RECT,
		ST_DRAIN,
		ST_RESULT,
		ST_HDR0,
		ST_HDR1,
		ST_RD,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [BUF_AW-1:0] rd_addr;
		logic              wr_en;
		logic [BUF_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
	} ram_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] frame_word;
		logic        frame_valid;
		logic        last;
	} res_t;

	// flipped row, lower half folds into byte columns 16 to 31
	function automatic logic [BUF_AW-1:0] byte_addr(input logic [5:0] y, input logic [3:0] c);
		logic [5:0] r;
		r = ~y;
		return {r[4:0], r[5], c};
	endfunction

	function automatic logic [7:0] span_mask(input logic [3:0] c, input logic [3:0] c_lo,
		input logic [3:0] c_hi, input logic [2:0] x_lo, input logic [2:0] x_hi);
		logic [7:0] m;
		m = 8'hFF;
		if (c == c_lo)
			m = m & (8'hFF >> x_lo);
		if (c == c_hi)
			m = m & ~(8'h7F >> x_hi);
		return m;
	endfunction

	function automatic logic [23:0] make_frame(input logic [7:0] sync, input logic [7:0] d);
		return {sync, d[7:4], 4'b0000, d[3:0], 4'b0000};
	endfunction

endpackage

// ===== src/fbd_ram.sv =====
// 1024 x 8 frame buffer memory, one write and one read port, registered read data
// depends on fbd_pkg
module fbd_ram
	import fbd_pkg::*;
(
	input  logic     clk,
	input  ram_req_t req,
	output logic [7:0] rd_data
);

	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/fbd_ctrl.sv =====
// command sequencer: clearing sweep, rectangle read-modify-write walk, row streaming
// depends on fbd_pkg; drives fbd_ram and the result register
module fbd_ctrl
	import fbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] x_a,
	input  logic [7:0] y_a,
	input  logic [7:0] x_b,
	input  logic [7:0] y_b,
	input  logic       color,
	input  logic [4:0] row_sel,
	output ram_req_t   ram_req,
	input  logic [7:0] rd_data,
	input  logic       res_free,
	output logic       res_load,
	output res_t       res
);

	state_t state_q, state_d;

	logic [BUF_AW-1:0] clr_cnt_q;
	logic              clr_reply_q;
	logic [2:0]        sts_q;
	op_t               op_q;
	logic [5:0]        y_q, yend_q;
	logic [3:0]        c_q, cstart_q, cend_q;
	logic [2:0]        xlo_q, xhi_q;
	logic [4:0]        row_q;
	logic [COL_W-1:0]  k_q;

	logic              vld_s1;
	logic [BUF_AW-1:0] addr_s1;
	logic [7:0]        mask_s1;
	op_t               op_s1;

	logic       in_acc;
	logic       xa_ov, ya_ov, xb_ov, yb_ov;
	logic [6:0] xa_c, xb_c, xlo7, xhi7;
	logic [5:0] ya_c, yb_c, ylo6, yhi6;
	status_t    sts_rect, sts_pix, sts_new;
	logic       rect_end;
	logic [7:0] mod_data;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// corner checks, clamping and sorting
	always_comb begin
		xa_ov = x_a[7];
		ya_ov = |y_a[7:6];
		xb_ov = x_b[7];
		yb_ov = |y_b[7:6];
		xa_c  = xa_ov ? MAX_X : x_a[6:0];
		ya_c  = ya_ov ? MAX_Y : y_a[5:0];
		xb_c  = xb_ov ? MAX_X : x_b[6:0];
		yb_c  = yb_ov ? MAX_Y : y_b[5:0];
		if (xa_ov)
			sts_rect = STS_XA;
		else if (ya_ov)
			sts_rect = STS_YA;
		else if (xb_ov)
			sts_rect = STS_XB;
		else if (yb_ov)
			sts_rect = STS_YB;
		else
			sts_rect = STS_OK;
		if (xa_ov)
			sts_pix = STS_XA;
		else if (ya_ov)
			sts_pix = STS_YA;
		else
			sts_pix = STS_OK;
		if (cmd == CMD_PIXEL) begin
			sts_new = sts_pix;
			xlo7    = x_a[6:0];
			xhi7    = x_a[6:0];
			ylo6    = y_a[5:0];
			yhi6    = y_a[5:0];
		end else begin
			sts_new = (cmd == CMD_FILL || cmd == CMD_INV) ? sts_rect : STS_OK;
			xlo7    = (xa_c > xb_c) ? xb_c : xa_c;
			xhi7    = (xa_c > xb_c) ? xa_c : xb_c;
			ylo6    = (ya_c > yb_c) ? yb_c : ya_c;
			yhi6    = (ya_c > yb_c) ? ya_c : yb_c;
		end
	end

	assign rect_end = (c_q == cend_q) && (y_q == yend_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ADDR)
					state_d = clr_reply_q ? ST_RESULT : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd)
						CMD_PIXEL: state_d = (sts_pix != STS_OK) ? ST_RESULT : ST_RECT;
						CMD_FILL:  state_d = ST_RECT;
						CMD_INV:   state_d = ST_RECT;
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_ROW:   state_d = ST_HDR0;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_RECT: begin
				if (rect_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (res_free)
					state_d = ST_IDLE;
			end
			ST_HDR0: begin
				if (res_free)
					state_d = ST_HDR1;
			end
			ST_HDR1: begin
				if (res_free)
					state_d = ST_RD;
			end
			ST_RD:     state_d = ST_DATA;
			ST_DATA: begin
				if (res_free)
					state_d = (k_q == LAST_COL) ? ST_IDLE : ST_RD;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// read-modify-write data for the byte in stage 1
	always_comb begin
		case (op_s1)
			OP_SET:  mod_data = rd_data | mask_s1;
			OP_INV:  mod_data = rd_data ^ mask_s1;
			default: mod_data = rd_data & ~mask_s1;
		endcase
	end

	// outputs
	always_comb begin
		ram_req.rd_en   = 1'b0;
		ram_req.rd_addr = byte_addr(y_q, c_q);
		ram_req.wr_en   = vld_s1;
		ram_req.wr_addr = addr_s1;
		ram_req.wr_data = mod_data;
		res_load        = 1'b0;
		res.status      = STS_OK;
		res.frame_word  = '0;
		res.frame_valid = 1'b1;
		res.last        = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = clr_cnt_q;
				ram_req.wr_data = '0;
			end
			ST_RECT: begin
				ram_req.rd_en = 1'b1;
			end
			ST_RESULT: begin
				res_load        = res_free;
				res.status      = sts_q;
				res.frame_valid = 1'b0;
				res.last        = 1'b1;
			end
			ST_HDR0: begin
				res_load       = res_free;
				res.frame_word = make_frame(SYNC_CMD, ROW_CMD | {3'b000, row_q});
			end
			ST_HDR1: begin
				res_load       = res_free;
				res.frame_word = make_frame(SYNC_CMD, ROW_CMD);
			end
			ST_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = {row_q, k_q};
			end
			ST_DATA: begin
				res_load       = res_free;
				res.frame_word = make_frame(SYNC_DATA, rd_data);
				res.last       = (k_q == LAST_COL);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			vld_s1      <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_RECT);
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (in_acc) begin
				clr_reply_q <= 1'b1;
				k_q         <= '0;
			end else if (state_q == ST_DATA && res_free) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sts_q    <= sts_new;
			op_q     <= (cmd == CMD_INV) ? OP_INV : (color ? OP_SET : OP_CLR);
			y_q      <= ylo6;
			yend_q   <= yhi6;
			c_q      <= xlo7[6:3];
			cstart_q <= xlo7[6:3];
			cend_q   <= xhi7[6:3];
			xlo_q    <= xlo7[2:0];
			xhi_q    <= xhi7[2:0];
			row_q    <= row_sel;
		end else if (state_q == ST_RECT) begin
			if (c_q == cend_q) begin
				c_q <= cstart_q;
				y_q <= y_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
		addr_s1 <= byte_addr(y_q, c_q);
		mask_s1 <= span_mask(c_q, cstart_q, cend_q, xlo_q, xhi_q);
		op_s1   <= op_q;
	end

endmodule

// ===== src/fbd_out.sv =====
// output result register with valid/stall handshake
// depends on fbd_pkg; loaded by fbd_ctrl
module fbd_out
	import fbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_load,
	input  res_t        res,
	output logic        res_free,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [23:0] frame_word,
	output logic        frame_valid,
	output logic        last
);

	logic valid_q;
	res_t res_q;

	assign res_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res;
	end

	assign out_valid   = valid_q;
	assign status      = res_q.status;
	assign frame_word  = res_q.frame_word;
	assign frame_valid = res_q.frame_valid;
	assign last        = res_q.last;

endmodule

// ===== src/mono_framebuffer_draw_engine_top.sv =====
// 128x64 one-bit frame buffer draw engine, top level
// depends on fbd_pkg, fbd_ram, fbd_ctrl, fbd_out and the top-level assertion macros
//
// One command beat at a time. After reset the buffer is swept to white, one byte a cycle,
// before the first beat is taken; a clear command runs the same sweep. Fill and invert
// walk the rectangle one buffer byte per cycle through the single memory read port; a
// pixel is one byte. A row stream delivers 34 beats, each data byte read from memory
// before its beat is loaded, and waits while the result register is full.
// The result register lets the next command start while the last result beat waits.
`include "mono_framebuffer_draw_engine_top_macros.svh"

module mono_framebuffer_draw_engine_top
	import fbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  x_a,
	input  logic [7:0]  y_a,
	input  logic [7:0]  x_b,
	input  logic [7:0]  y_b,
	input  logic        color,
	input  logic [4:0]  row_sel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [23:0] frame_word,
	output logic        frame_valid,
	output logic        last
);

	ram_req_t   ram_req;
	logic [7:0] rd_data;
	logic       res_free;
	logic       res_load;
	res_t       res;

	fbd_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	fbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.x_a      (x_a),
		.y_a      (y_a),
		.x_b      (x_b),
		.y_b      (y_b),
		.color    (color),
		.row_sel  (row_sel),
		.ram_req  (ram_req),
		.rd_data  (rd_data),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	fbd_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_load    (res_load),
		.res         (res),
		.res_free    (res_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.frame_word  (frame_word),
		.frame_valid (frame_valid),
		.last        (last)
	);

	`FBD_ASSERT_NOW(a_rmw_no_overlap, ram_req.wr_en && ram_req.rd_en, ram_req.wr_addr != ram_req.rd_addr, "read and write hit the same byte")
	`FBD_ASSERT_NEXT(a_busy_after_cmd, in_valid && !in_stall, in_stall, "engine idle right after a command beat")
	`FBD_ASSERT_NOW(a_frame_status_ok, out_valid && frame_valid, status == STS_OK, "frame beat with error status")
	`FBD_ASSERT_NOW(a_mid_is_frame, out_valid && !last, frame_valid, "non-final beat without a frame")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the 128x64 frame buffer draw engine
// holds a byte-level model of the buffer and checks every result beat in order
// depends on fbd_pkg and mono_framebuffer_draw_engine_top
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fbd_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int RANDOM_ITEMS   = 475;
	localparam int CALM_ITEMS     = 100;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int REPORT_LIMIT   = 10;

	class framebuffer_model;
		logic [7:0] pixels [BUFFER_BYTES];
		res_t       pending_beats [$];
		int         mismatches;

		function new();
			wipe();
			mismatches = 0;
		endfunction

		function void wipe();
			foreach (pixels[i])
				pixels[i] = 8'h00;
		endfunction

		// flipped row, rows 32 and up fold into byte columns 16 to 31
		function int pixel_byte(int x, int y);
			int r;
			int col;
			r   = int'(MAX_Y) - y;
			col = x / 8;
			if (r > 31) begin
				col += 16;
				r   -= 32;
			end
			return r * ROW_BYTES + col;
		endfunction

		function void paint(int x, int y, op_t op);
			int idx;
			logic [7:0] mask;
			idx  = pixel_byte(x, y);
			mask = 8'h80 >> (x % 8);
			case (op)
				OP_SET: pixels[idx] = pixels[idx] | mask;
				OP_CLR: pixels[idx] = pixels[idx] & ~mask;
				default: pixels[idx] = pixels[idx] ^ mask;
			endcase
		endfunction

		function status_t draw_rect(int xa, int ya, int xb, int yb, op_t op);
			status_t sts;
			int t;
			sts = STS_OK;
			if (xa > MAX_X) begin
				xa = MAX_X;
				if (sts == STS_OK) sts = STS_XA;
			end
			if (ya > MAX_Y) begin
				ya = MAX_Y;
				if (sts == STS_OK) sts = STS_YA;
			end
			if (xb > MAX_X) begin
				xb = MAX_X;
				if (sts == STS_OK) sts = STS_XB;
			end
			if (yb > MAX_Y) begin
				yb = MAX_Y;
				if (sts == STS_OK) sts = STS_YB;
			end
			if (xa > xb) begin
				t  = xa;
				xa = xb;
				xb = t;
			end
			if (ya > yb) begin
				t  = ya;
				ya = yb;
				yb = t;
			end
			for (int y = ya; y <= yb; y++)
				for (int x = xa; x <= xb; x++)
					paint(x, y, op);
			return sts;
		endfunction

		function logic [23:0] serial_frame(logic [7:0] sync, logic [7:0] d);
			return {sync, d[7:4], 4'h0, d[3:0], 4'h0};
		endfunction

		function void note_command(logic [2:0] c, logic [7:0] xa, logic [7:0] ya,
			logic [7:0] xb, logic [7:0] yb, logic black, logic [4:0] row);
			status_t sts;
			op_t     draw_op;
			int      base;
			sts     = STS_OK;
			draw_op = black ? OP_SET : OP_CLR;
			base    = int'(row) * ROW_BYTES;
			case (c)
				CMD_PIXEL: begin
					if (xa > MAX_X)
						sts = STS_XA;
					else if (ya > MAX_Y)
						sts = STS_YA;
					else
						paint(xa, ya, draw_op);
				end
				CMD_FILL: sts = draw_rect(xa, ya, xb, yb, draw_op);
				CMD_INV: sts = draw_rect(xa, ya, xb, yb, OP_INV);
				CMD_CLEAR: wipe();
				CMD_ROW: begin
					pending_beats.push_back('{STS_OK, serial_frame(SYNC_CMD, ROW_CMD + row),
						1'b1, 1'b0});
					pending_beats.push_back('{STS_OK, serial_frame(SYNC_CMD, ROW_CMD),
						1'b1, 1'b0});
					for (int k = 0; k < ROW_BYTES; k++)
						pending_beats.push_back('{STS_OK,
							serial_frame(SYNC_DATA, pixels[base + k]), 1'b1,
							k == ROW_BYTES - 1});
					return;
				end
				default: ;
			endcase
			pending_beats.push_back('{sts, 24'h000000, 1'b0, 1'b1});
		endfunction

		function void check_beat(res_t got);
			res_t want;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: status %0d frame %h valid %b last %b",
						got.status, got.frame_word, got.frame_valid, got.last);
				return;
			end
			want = pending_beats.pop_front();
			if (got.status !== want.status || got.frame_word !== want.frame_word ||
				got.frame_valid !== want.frame_valid || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected status %0d frame %h valid %b last %b, %s",
						want.status, want.frame_word, want.frame_valid, want.last,
						$sformatf("got status %0d frame %h valid %b last %b",
						got.status, got.frame_word, got.frame_valid, got.last));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [7:0]  x_a;
	logic [7:0]  y_a;
	logic [7:0]  x_b;
	logic [7:0]  y_b;
	logic        color;
	logic [4:0]  row_sel;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [23:0] frame_word;
	logic        frame_valid;
	logic        last;

	framebuffer_model board;
	bit gaps_on;
	int beats_seen;

	mono_framebuffer_draw_engine_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.x_a         (x_a),
		.y_a         (y_a),
		.x_b         (x_b),
		.y_b         (y_b),
		.color       (color),
		.row_sel     (row_sel),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.frame_word  (frame_word),
		.frame_valid (frame_valid),
		.last        (last)
	);

	always #5ns clk = ~clk;

	function automatic logic [7:0] any_byte();
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] coord_x();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	function automatic logic [7:0] coord_y();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(64, 255));
		return 8'($urandom_range(0, 63));
	endfunction

	task automatic issue_command(logic [2:0] c, logic [7:0] xa, logic [7:0] ya,
		logic [7:0] xb, logic [7:0] yb, logic col, logic [4:0] row);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		x_a      <= xa;
		y_a      <= ya;
		x_b      <= xb;
		y_b      <= yb;
		color    <= col;
		row_sel  <= row;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// results are checked before the beat accepted at the same edge is noted
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			board.check_beat('{status, frame_word, frame_valid, last});
		end
		if (arst_n && in_valid && !in_stall)
			board.note_command(cmd, x_a, y_a, x_b, y_b, color, row_sel);
	end

	// receiver side, with one long hold-off so the input backs up
	initial begin
		bit held;
		held      = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && beats_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("testbench failed");
		$finish;
	end

	initial begin
		int pick;
		logic [2:0] c;
		logic [7:0] xa;
		logic [7:0] ya;
		logic [7:0] xb;
		logic [7:0] yb;
		board      = new();
		beats_seen = 0;
		gaps_on    = 1'b1;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_PIXEL;
		x_a        = 8'h00;
		y_a        = 8'h00;
		x_b        = 8'h00;
		y_b        = 8'h00;
		color      = 1'b0;
		row_sel    = 5'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// corners of the screen and both halves of the folded layout
		issue_command(CMD_PIXEL, 8'd0, 8'd0, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd127, 8'd63, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd8, 8'd32, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd71, 8'd31, any_byte(), any_byte(), 1'b1, 5'($urandom));
		// pixel out of range, x reported ahead of y
		issue_command(CMD_PIXEL, 8'd128, 8'd5, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd255, 8'd255, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd3, 8'd64, any_byte(), any_byte(), 1'b1, 5'($urandom));
		issue_command(CMD_PIXEL, 8'd3, 8'd255, any_byte(), any_byte(), 1'b0, 5'($urandom));
		issue_command(CMD_ROW, any_byte(), any_byte(), any_byte(), any_byte(), 1'b1, 5'd0);
		issue_command(CMD_ROW, any_byte(), any_byte(), any_byte(), any_byte(), 1'b0, 5'd31);
		issue_command(CMD_PIXEL, 8'd0, 8'd0, any_byte(), any_byte(), 1'b0, 5'($urandom));
		// full screen, then reversed corners and clamped corners
		issue_command(CMD_FILL, 8'd0, 8'd0, 8'd127, 8'd63, 1'b1, 5'($urandom));
		issue_command(CMD_ROW, any_byte(), any_byte(), any_byte(), any_byte(), 1'b1, 5'd7);
		issue_command(CMD_FILL, 8'd100, 8'd50, 8'd10, 8'd5, 1'b0, 5'($urandom));
		issue_command(CMD_INV, 8'd255, 8'd70, 8'd3, 8'd2, 1'b1, 5'($urandom));
		issue_command(CMD_FILL, 8'd5, 8'd70, 8'd3, 8'd2, 1'b1, 5'($urandom));
		issue_command(CMD_INV, 8'd5, 8'd5, 8'd130, 8'd2, 1'b0, 5'($urandom));
		issue_command(CMD_FILL, 8'd5, 8'd5, 8'd6, 8'd64, 1'b0, 5'($urandom));
		issue_command(CMD_INV, 8'd40, 8'd20, 8'd40, 8'd20, 1'b1, 5'($urandom));
		issue_command(CMD_ROW, any_byte(), any_byte(), any_byte(), any_byte(), 1'b0, 5'd20);
		issue_command(CMD_CLEAR, any_byte(), any_byte(), any_byte(), any_byte(), 1'b1,
			5'($urandom));
		for (int s = CMD_SPARE_FIRST; s <= CMD_SPARE_LAST; s++)
			issue_command(3'(s), any_byte(), any_byte(), any_byte(), any_byte(),
				1'($urandom), 5'($urandom));
		issue_command(CMD_ROW, any_byte(), any_byte(), any_byte(), any_byte(), 1'b1, 5'd31);

		// mostly small shapes with row reads in between to observe them
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				gaps_on = (n < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				c = CMD_PIXEL;
			else if (pick < 48)
				c = CMD_FILL;
			else if (pick < 62)
				c = CMD_INV;
			else if (pick < 64)
				c = CMD_CLEAR;
			else if (pick < 94)
				c = CMD_ROW;
			else
				c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			xa = coord_x();
			ya = coord_y();
			if ($urandom_range(0, 6) == 0) begin
				xb = coord_x();
				yb = coord_y();
			end else begin
				xb = 8'(xa + $urandom_range(0, 24) - 12);
				yb = 8'(ya + $urandom_range(0, 12) - 6);
			end
			issue_command(c, xa, ya, xb, yb, 1'($urandom), 5'($urandom));
		end
		in_valid <= 1'b0;
		// let the monitor note the final beat before waiting on the queue
		@(posedge clk);

		while (board.pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== mono_framebuffer_draw_engine_top.f =====
+incdir+src
src/fbd_pkg.sv
src/fbd_ram.sv
src/fbd_ctrl.sv
src/fbd_out.sv
src/mono_framebuffer_draw_engine_top.sv
tb/sv/testbench.sv
